@@ hdl/crn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package crn_pkg;

    // Default sizes of the block.
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed-point format and fixed field widths.
    localparam int FRAC_BITS = 16;
    localparam int COL_W     = 6;
    localparam int CNT_W     = 32;
    localparam int CCOL_W    = 7;

    // Counter limits.
    localparam logic [CNT_W-1:0]  CLIP_TOTAL_MAX = '1;
    localparam logic [CCOL_W-1:0] CLIP_COLS_MAX  = '1;

    // Mode register codes.
    localparam logic MODE_TRAIN = 1'b0;
    localparam logic MODE_TEST  = 1'b1;

endpackage
`default_nettype wire

@@ hdl/column_range_normalizer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Min-max range normalizer for feature columns of signed Q16.16 values.
// Input stream (s_*): tdata carries the value and its column, tlast marks the
// last value of a column. The cfg channel writes the mode bit: 0 trains, 1 tests.
// Training: values are buffered and min/max tracked; no result until tlast.
// On tlast the column's range and minimum are stored and every buffered value
// (up to MAX_ROWS) is sent divided by the range, tlast on the final one.
// Test: each value is looked up, clipped to the stored range, divided and sent
// as one result; clip counters travel with every result.
// Each result passes through a buffer or table read, DATA_WIDTH+17 steps of
// the bit-serial divider, and the states that collect the quotient and load
// the output register. A zero range skips the divider. One value at a time
// is held; s_tready is high only while the block waits for input.
// A result waits in the output register while m_tready is low; the next result
// is held in the sequencer until the register is free. Reset clears the
// counters, the mode, the running min/max and all table valid bits (tables
// read as zero); no clearing pass is needed.
module column_range_normalizer_unit #(
    parameter int MAX_ROWS   = crn_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = crn_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = crn_pkg::DEF_DATA_WIDTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // Mode register write.
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic cfg_data,
    // Input: sample_value, column_index (from bit 0 up), zero padded.
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire logic [((DATA_WIDTH+crn_pkg::COL_W+7)/8)*8-1:0] s_tdata,
    input  wire logic s_tlast,
    // Output: normalized_value, out_column, column_range, column_minimum,
    // clipped_total, clipped_columns (from bit 0 up), zero padded.
    output logic      m_tvalid,
    input  wire logic m_tready,
    output logic [((3*DATA_WIDTH+crn_pkg::COL_W+1+crn_pkg::CNT_W+crn_pkg::CCOL_W+7)/8)*8-1:0]
                      m_tdata,
    output logic      m_tlast,
    // Output tuser: was_clipped.
    output logic      m_tuser
);
    import crn_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int RAW  = $clog2(MAX_ROWS);
    localparam int RCW  = $clog2(MAX_ROWS + 1);
    localparam int CAW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CXW  = 11;
    localparam int TW   = 2 * DW + 1;
    localparam int ODW  = 3 * DW + COL_W + 1 + CNT_W + CCOL_W;
    localparam int OTW  = ((ODW + 7) / 8) * 8;
    localparam logic signed [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] NEG_MAX = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_BREQ,
        ST_BDATA,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic                   mode_reg;
    logic [RCW-1:0]         row_count_reg;
    logic signed [DW-1:0]   run_min_reg;
    logic signed [DW-1:0]   run_max_reg;
    logic [MAX_COLS-1:0]    tbl_valid_reg;
    logic [CNT_W-1:0]       clip_total_reg;
    logic [CCOL_W-1:0]      clip_cols_reg;
    logic                   had_clip_reg;
    logic [RCW-1:0]         k_reg;
    logic [RCW-1:0]         n_reg;
    logic signed [DW-1:0]   val_reg;
    logic [COL_W-1:0]       col_reg;
    logic                   end_reg;
    logic                   in_range_reg;
    logic [DW:0]            rng_reg;
    logic signed [DW-1:0]   mn_reg;
    logic                   clip_reg;
    logic                   last_reg;
    logic [DW-1:0]          q_reg;
    logic                   m_tvalid_reg;
    logic [OTW-1:0]         m_tdata_reg;
    logic                   m_tlast_reg;
    logic                   m_tuser_reg;

    logic                   accept;
    logic signed [DW-1:0]   s_val;
    logic [COL_W-1:0]       s_col;
    logic [CXW-1:0]         s_col_x;
    logic [CXW-1:0]         col_reg_x;
    logic                   s_in_range;
    logic signed [DW-1:0]   min_new;
    logic signed [DW-1:0]   max_new;
    logic [DW:0]            rng_new;
    logic                   buf_we;
    logic [DW-1:0]          buf_rdata;
    logic                   tbl_we;
    logic [TW-1:0]          tbl_rdata;
    logic [DW:0]            look_rng;
    logic signed [DW-1:0]   look_mn;
    logic signed [DW+1:0]   look_hi;
    logic signed [DW-1:0]   look_val;
    logic                   look_clip;
    logic                   div_start;
    logic signed [DW-1:0]   div_dividend;
    logic [DW:0]            div_divisor;
    logic                   div_done;
    logic [DW-1:0]          div_q;
    logic                   out_free;
    logic                   out_load;

    // Input field split and column bounds.
    assign s_val      = s_tdata[DW-1:0];
    assign s_col      = s_tdata[DW+COL_W-1:DW];
    assign s_col_x    = CXW'(s_col);
    assign col_reg_x  = CXW'(col_reg);
    assign s_in_range = s_col_x < CXW'(MAX_COLS);
    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = (state_reg == ST_OUT) && out_free;

    // Running extremes including the value being accepted.
    assign min_new = (s_val < run_min_reg) ? s_val : run_min_reg;
    assign max_new = (s_val > run_max_reg) ? s_val : run_max_reg;
    assign rng_new = (DW+1)'({max_new[DW-1], max_new} - {min_new[DW-1], min_new});

    // Memory write strobes on an accepted training value.
    assign buf_we = accept && (mode_reg == MODE_TRAIN) && (row_count_reg < RCW'(MAX_ROWS));
    assign tbl_we = accept && (mode_reg == MODE_TRAIN) && s_tlast && s_in_range;

    crn_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (row_count_reg[RAW-1:0]),
        .wdata (s_val),
        .raddr (k_reg[RAW-1:0]),
        .rdata (buf_rdata)
    );

    crn_ram #(.WIDTH(TW), .DEPTH(MAX_COLS)) u_tbl (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (s_col_x[CAW-1:0]),
        .wdata ({rng_new, min_new}),
        .raddr (s_col_x[CAW-1:0]),
        .rdata (tbl_rdata)
    );

    // Test lookup: untrained columns read as zero, then clip to the stored range.
    always_comb begin
        look_rng = '0;
        look_mn  = '0;
        if (in_range_reg && tbl_valid_reg[col_reg_x[CAW-1:0]]) begin
            look_rng = tbl_rdata[TW-1:DW];
            look_mn  = tbl_rdata[DW-1:0];
        end
        look_hi   = (DW+2)'(look_mn) + (DW+2)'({1'b0, look_rng});
        look_val  = val_reg;
        look_clip = 1'b0;
        if (look_rng != '0) begin
            if ((DW+2)'(val_reg) > look_hi) begin
                look_val  = look_hi[DW-1:0];
                look_clip = 1'b1;
            end else if (val_reg < look_mn) begin
                look_val  = look_mn;
                look_clip = 1'b1;
            end
        end
    end

    // Divider launch from either path.
    assign div_start    = ((state_reg == ST_LOOK) && (look_rng != '0)) ||
                          ((state_reg == ST_BDATA) && (rng_reg != '0));
    assign div_dividend = (state_reg == ST_LOOK) ? look_val : buf_rdata;
    assign div_divisor  = (state_reg == ST_LOOK) ? look_rng : rng_reg;

    crn_div #(.DATA_WIDTH(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer, state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_TRAIN;
            row_count_reg  <= '0;
            run_min_reg    <= POS_MAX;
            run_max_reg    <= NEG_MAX;
            tbl_valid_reg  <= '0;
            clip_total_reg <= '0;
            clip_cols_reg  <= '0;
            had_clip_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && (mode_reg == MODE_TRAIN)) begin
                        if (buf_we) begin
                            row_count_reg <= row_count_reg + RCW'(1);
                        end
                        if (s_tlast) begin
                            if (s_in_range) begin
                                tbl_valid_reg[s_col_x[CAW-1:0]] <= 1'b1;
                            end
                            n_reg         <= buf_we ? row_count_reg + RCW'(1)
                                                    : row_count_reg;
                            k_reg         <= '0;
                            rng_reg       <= rng_new;
                            mn_reg        <= min_new;
                            col_reg       <= s_col;
                            clip_reg      <= 1'b0;
                            row_count_reg <= '0;
                            run_min_reg   <= POS_MAX;
                            run_max_reg   <= NEG_MAX;
                            state_reg     <= ST_BREQ;
                        end else begin
                            run_min_reg <= min_new;
                            run_max_reg <= max_new;
                        end
                    end else if (accept) begin
                        val_reg      <= s_val;
                        col_reg      <= s_col;
                        end_reg      <= s_tlast;
                        in_range_reg <= s_in_range;
                        state_reg    <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    rng_reg  <= look_rng;
                    mn_reg   <= look_mn;
                    clip_reg <= look_clip;
                    last_reg <= 1'b1;
                    q_reg    <= '0;
                    if (look_clip && (clip_total_reg != CLIP_TOTAL_MAX)) begin
                        clip_total_reg <= clip_total_reg + CNT_W'(1);
                    end
                    if (end_reg) begin
                        if ((had_clip_reg || look_clip) && (clip_cols_reg != CLIP_COLS_MAX)) begin
                            clip_cols_reg <= clip_cols_reg + CCOL_W'(1);
                        end
                        had_clip_reg <= 1'b0;
                    end else if (look_clip) begin
                        had_clip_reg <= 1'b1;
                    end
                    state_reg <= (look_rng != '0) ? ST_DIV : ST_OUT;
                end
                ST_BREQ: begin
                    state_reg <= ST_BDATA;
                end
                ST_BDATA: begin
                    last_reg  <= (k_reg + RCW'(1)) == n_reg;
                    q_reg     <= '0;
                    state_reg <= (rng_reg != '0) ? ST_DIV : ST_OUT;
                end
                ST_DIV: begin
                    if (div_done) begin
                        q_reg     <= div_q;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= OTW'({clip_cols_reg, clip_total_reg, mn_reg,
                                              rng_reg, col_reg, q_reg});
                        m_tlast_reg  <= last_reg;
                        m_tuser_reg  <= clip_reg;
                        if (last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + RCW'(1);
                            state_reg <= ST_BREQ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

@@ hdl/crn_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module crn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hdl/crn_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module crn_div #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic signed [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH:0]          divisor,
    output logic                              done,
    output logic [DATA_WIDTH-1:0]             quotient
);
    import crn_pkg::*;

    localparam int QW  = DATA_WIDTH + 1 + FRAC_BITS;
    localparam int RW  = DATA_WIDTH + 2;
    localparam int CW  = $clog2(QW + 1);
    localparam logic [QW-1:0] SIGN_LIM = QW'(1) << (DATA_WIDTH - 1);

    logic [QW-1:0]        num_reg;
    logic [RW-1:0]        rem_reg;
    logic [DATA_WIDTH:0]  den_reg;
    logic                 neg_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DATA_WIDTH:0]  mag;
    logic [RW-1:0]        shifted;
    logic                 fits;
    logic [QW-1:0]        lim;
    logic [QW-1:0]        q_sat;

    // Magnitude of the signed dividend, one bit wider to hold the most negative value.
    assign mag = dividend[DATA_WIDTH-1] ? (DATA_WIDTH+1)'(0) - {dividend[DATA_WIDTH-1], dividend}
                                        : {1'b0, dividend};

    // One restoring step: bring in the next dividend bit and try a subtract.
    assign shifted = {rem_reg[RW-2:0], num_reg[QW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
                num_reg  <= {mag, {FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                den_reg  <= divisor;
                neg_reg  <= dividend[DATA_WIDTH-1];
            end else if (busy_reg) begin
                rem_reg <= fits ? shifted - {1'b0, den_reg} : shifted;
                num_reg <= {num_reg[QW-2:0], fits};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Saturate to the signed range and restore the sign.
    assign lim      = neg_reg ? SIGN_LIM : SIGN_LIM - QW'(1);
    assign q_sat    = (num_reg > lim) ? lim : num_reg;
    assign quotient = neg_reg ? DATA_WIDTH'(QW'(0) - q_sat) : DATA_WIDTH'(q_sat);
    assign done     = done_reg;

endmodule
`default_nettype wire

@@ verif/crn_scoreboard.sv @@
`timescale 1ns / 1ps
module crn_scoreboard
    import crn_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // sample_value [31:0], column_index [37:32]
    input  logic [39:0]  s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // normalized_value, out_column, column_range, column_minimum,
    // clipped_total, clipped_columns
    input  logic [143:0] m_tdata,
    input  logic         m_tlast,
    // was_clipped
    input  logic         m_tuser,
    output int           mismatch_count,
    output int           pending_count,
    output int           result_count,
    output int           clip_result_count
);

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  column;
        logic        clipped;
        logic        last;
        logic [32:0] span;
        logic [31:0] floor_val;
        logic [31:0] clip_total;
        logic [6:0]  clip_cols;
    } norm_result_t;

    norm_result_t expected_q[$];

    longint      row_buf[64];
    int          rows;
    longint      run_min;
    longint      run_max;
    longint      span_tab[64];
    longint      floor_tab[64];
    longint      clip_total;
    int          clip_cols;
    bit          had_clip;
    logic        mode_r;

    assign pending_count = expected_q.size();

    // Signed Q16.16 quotient with truncation toward zero and saturation.
    function automatic logic [31:0] scaled_quotient(longint v, longint r);
        bit     neg;
        longint mag;
        longint q;
        longint lim;
        neg = v < 0;
        mag = neg ? -v : v;
        q   = (mag <<< FRAC_BITS) / r;
        lim = neg ? 64'sh80000000 : 64'sh7FFFFFFF;
        if (q > lim) q = lim;
        return neg ? 32'(-q) : 32'(q);
    endfunction

    // Predict the results of one accepted sample.
    task automatic predict_sample(logic [31:0] raw, logic [5:0] col, logic fin);
        longint       v;
        longint       span;
        longint       fl;
        longint       hi;
        norm_result_t r;
        bit           clp;
        v = longint'($signed(raw));
        if (mode_r == MODE_TRAIN) begin
            if (v < run_min) run_min = v;
            if (v > run_max) run_max = v;
            if (rows < 64) begin
                row_buf[rows] = v;
                rows++;
            end
            if (fin) begin
                span = run_max - run_min;
                fl   = run_min;
                span_tab[col]  = span;
                floor_tab[col] = fl;
                for (int k = 0; k < rows; k++) begin
                    r.value      = (span == 0) ? 32'd0 : scaled_quotient(row_buf[k], span);
                    r.column     = col;
                    r.clipped    = 1'b0;
                    r.last       = (k == rows - 1);
                    r.span       = 33'(span);
                    r.floor_val  = 32'(fl);
                    r.clip_total = 32'(clip_total);
                    r.clip_cols  = 7'(clip_cols);
                    expected_q.push_back(r);
                end
                rows    = 0;
                run_min = 64'sh7FFFFFFF;
                run_max = -64'sh80000000;
            end
        end else begin
            span = span_tab[col];
            fl   = floor_tab[col];
            clp  = 1'b0;
            r.value = '0;
            if (span != 0) begin
                hi = fl + span;
                if (v > hi) begin
                    v = hi;
                    clp = 1'b1;
                end else if (v < fl) begin
                    v = fl;
                    clp = 1'b1;
                end
                if (clp) begin
                    if (clip_total < 64'hFFFFFFFF) clip_total++;
                    had_clip = 1'b1;
                end
                r.value = scaled_quotient(v, span);
            end
            if (fin) begin
                if (had_clip && clip_cols < 127) clip_cols++;
                had_clip = 1'b0;
            end
            r.column     = col;
            r.clipped    = clp;
            r.last       = 1'b1;
            r.span       = 33'(span);
            r.floor_val  = 32'(fl);
            r.clip_total = 32'(clip_total);
            r.clip_cols  = 7'(clip_cols);
            expected_q.push_back(r);
        end
    endtask

    // Report one mismatch; only the first ten are printed.
    task automatic flag_mismatch(string what, norm_result_t exp_r, norm_result_t got_r);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch (%s): expected %h got %h", $realtime, what, exp_r, got_r);
    endtask

    // Compare output transactions, then track input and config transactions.
    // An input transaction uses the mode from before a config write in the same cycle.
    always @(posedge aclk) begin
        norm_result_t got_r;
        norm_result_t exp_r;
        if (!aresetn) begin
            expected_q.delete();
            for (int k = 0; k < 64; k++) begin
                row_buf[k]   = 0;
                span_tab[k]  = 0;
                floor_tab[k] = 0;
            end
            rows              = 0;
            run_min           = 64'sh7FFFFFFF;
            run_max           = -64'sh80000000;
            clip_total        = 0;
            clip_cols         = 0;
            had_clip          = 1'b0;
            mode_r            = MODE_TRAIN;
            mismatch_count    = 0;
            result_count      = 0;
            clip_result_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_r.value      = m_tdata[31:0];
                got_r.column     = m_tdata[37:32];
                got_r.span       = m_tdata[70:38];
                got_r.floor_val  = m_tdata[102:71];
                got_r.clip_total = m_tdata[134:103];
                got_r.clip_cols  = m_tdata[141:135];
                got_r.clipped    = m_tuser;
                got_r.last       = m_tlast;
                result_count++;
                if (m_tuser) clip_result_count++;
                if (expected_q.size() == 0) begin
                    exp_r = '0;
                    flag_mismatch("unexpected result", exp_r, got_r);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r !== exp_r) flag_mismatch("field", exp_r, got_r);
                end
            end
            if (s_tvalid && s_tready) predict_sample(s_tdata[31:0], s_tdata[37:32], s_tlast);
            if (cfg_valid && cfg_ready) mode_r = cfg_data;
        end
    end

endmodule

@@ verif/tb_column_range_normalizer_unit.sv @@
`timescale 1ns / 1ps
module tb_column_range_normalizer_unit;
    import crn_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // sample_value [31:0], column_index [37:32], zero padded
    logic [39:0]  s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // normalized_value, out_column, column_range, column_minimum,
    // clipped_total, clipped_columns, zero padded
    logic [143:0] m_tdata;
    logic         m_tlast;
    // was_clipped
    logic         m_tuser;

    int mismatch_count;
    int pending_count;
    int result_count;
    int clip_result_count;
    int sent_count = 0;
    int rx_gap = 0;
    bit long_hold_done = 1'b0;

    column_range_normalizer_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    crn_scoreboard u_scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .mismatch_count(mismatch_count), .pending_count(pending_count),
        .result_count(result_count), .clip_result_count(clip_result_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Receiver: random stalls, plus one long hold-off while the sender keeps going.
    always @(posedge aclk) begin
        int g;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
        end else begin
            g = 0;
            if (m_tvalid && m_tready) begin
                if (!long_hold_done && result_count == 30) begin
                    g = 600;
                    long_hold_done <= 1'b1;
                end else if (result_count > 60 && result_count < 120) begin
                    g = 0;
                end else begin
                    g = pick_gap();
                end
            end
            rx_gap   <= g;
            m_tready <= (g == 0);
        end
    end

    // Send one sample transaction after the given gap.
    task automatic send_sample(logic [31:0] value, logic [5:0] col, logic fin, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {2'b00, col, value};
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Change the mode once the block has drained.
    task automatic write_mode(logic m);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_sample(logic [31:0] center, int spread);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return center + $urandom_range(0, spread) - spread / 2;
        endcase
    endfunction

    // Train one column of the given length.
    task automatic train_column(logic [5:0] col, int len);
        logic [31:0] center;
        int          spread;
        center = $urandom_range(0, 3) == 0 ? $urandom
                                           : ($urandom_range(0, 255) << 16) - 32'h0080_0000;
        spread = $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000) : $urandom_range(0, 32'h3FFF_FFFF);
        for (int k = 0; k < len; k++)
            send_sample(rand_sample(center, spread), col, k == len - 1, pick_gap());
    endtask

    initial begin
        logic [5:0] col;
        int         len;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed training: full-scale range, zero range, single value, column switch.
        send_sample(32'h8000_0000, 6'd0, 1'b0, 0);
        send_sample(32'h7FFF_FFFF, 6'd0, 1'b0, 0);
        send_sample(32'h0000_0000, 6'd0, 1'b1, 0);
        send_sample(32'h0005_0000, 6'd1, 1'b0, 1);
        send_sample(32'h0005_0000, 6'd1, 1'b1, 0);
        send_sample(32'h0001_0000, 6'd2, 1'b1, 0);
        send_sample(32'hFFFD_0000, 6'd3, 1'b0, 0);
        send_sample(32'h0001_0000, 6'd3, 1'b0, 2);
        send_sample(32'h0007_8000, 6'd3, 1'b1, 0);
        send_sample(32'h0000_0001, 6'd4, 1'b0, 0);
        send_sample(32'hFFFF_FFFF, 6'd63, 1'b1, 0);

        // Directed test: in range, both clip sides, untrained, zero range, flag carry-over.
        write_mode(MODE_TEST);
        send_sample(32'h7FFF_FFFF, 6'd0, 1'b0, 0);
        send_sample(32'h8000_0000, 6'd0, 1'b1, 0);
        send_sample(32'h0002_0000, 6'd3, 1'b0, 0);
        send_sample(32'h8000_0000, 6'd3, 1'b0, 0);
        send_sample(32'h7FFF_FFFF, 6'd3, 1'b0, 0);
        send_sample(32'h0010_0000, 6'd7, 1'b0, 0);
        send_sample(32'h0005_0000, 6'd1, 1'b0, 0);
        send_sample(32'h1234_5678, 6'd63, 1'b1, 1);
        write_mode(MODE_TRAIN);

        // Buffer overflow: a column longer than the buffer.
        train_column(6'd10, 70);

        // Random phases of training and test.
        while (sent_count < 430) begin
            repeat ($urandom_range(3, 8)) begin
                col = 6'($urandom_range(0, 63));
                len = $urandom_range(0, 15) == 0 ? $urandom_range(40, 68) : $urandom_range(1, 8);
                train_column(col, len);
            end
            // A half-received column sometimes spans the mode change.
            if ($urandom_range(0, 2) == 0)
                send_sample(rand_sample(32'h0, 32'h0010_0000), 6'($urandom_range(0, 63)),
                            1'b0, 0);
            write_mode(MODE_TEST);
            repeat ($urandom_range(15, 40)) begin
                send_sample(rand_sample(($urandom_range(0, 255) << 16) - 32'h0080_0000,
                                        $urandom_range(0, 32'h0100_0000)),
                            6'($urandom_range(0, 63)), $urandom_range(0, 3) == 0, pick_gap());
            end
            write_mode(MODE_TRAIN);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Sent %0d samples over training and test phases; %0d results checked.",
                 sent_count, result_count);
        $display("%0d results carried the clip flag.", clip_result_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
